// ===== design/pfrw_pkg.sv =====
// Package for the pixel format rotate writer.
// Holds register codes, reset values and the structs passed between modules.
// Depends on nothing.
package pfrw_pkg;

	// Largest picture dimension the block honors.
	localparam int PFRW_MAX_DIM = 2048;

	// Field widths.
	localparam int COORD_W = 11;
	localparam int DIM_W   = 12;
	localparam int LINE_W  = 13;
	localparam int PIX_W   = 32;
	localparam int INDEX_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IS_WIDE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEIGHT = 3'd4;

	// Rotation codes.
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90   = 2'd1;
	localparam logic [1:0] ROT_180  = 2'd2;
	localparam logic [1:0] ROT_270  = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [LINE_W-1:0] LINE_WIDTH_RST     = 13'd640;
	localparam logic [DIM_W-1:0]  PICTURE_WIDTH_RST  = 12'd640;
	localparam logic [DIM_W-1:0]  PICTURE_HEIGHT_RST = 12'd480;

	// Alpha bytes of the destination pixel.
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Configuration as seen by the mapping logic.
	typedef struct packed {
		logic [1:0]        rotation;
		logic              source_is_wide;
		logic [DIM_W-1:0]  picture_width;
		logic [DIM_W-1:0]  picture_height;
	} cfg_t;

	// Result of the mapping stage: index = offset + line * line_width.
	typedef struct packed {
		logic [DIM_W-1:0] offset;
		logic [DIM_W-1:0] line;
		logic [PIX_W-1:0] pixel;
		logic             error;
	} map_t;

endpackage

// ===== design/pfrw_xlate.sv =====
// Coordinate mapping and pixel format conversion for one pixel.
// Purely combinational; sits between the input and mapping registers.
// Depends on pfrw_pkg.
module pfrw_xlate import pfrw_pkg::*; #(
	parameter int MAX_DIM = PFRW_MAX_DIM
) (
	input  cfg_t               cfg,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [PIX_W-1:0]   source_pixel,
	output map_t               map
);

	logic [DIM_W-1:0] w_lim;
	logic [DIM_W-1:0] h_lim;
	logic [DIM_W-1:0] x_ext;
	logic [DIM_W-1:0] y_ext;
	logic [DIM_W-1:0] x_flip;
	logic [DIM_W-1:0] y_flip;
	logic             err;
	logic [7:0]       alpha;
	logic [23:0]      color;

	// Clamp the picture size to the supported maximum.
	always_comb begin
		w_lim = cfg.picture_width;
		h_lim = cfg.picture_height;
		if ({1'b0, cfg.picture_width} > (DIM_W+1)'(MAX_DIM)) begin
			w_lim = DIM_W'(MAX_DIM);
		end
		if ({1'b0, cfg.picture_height} > (DIM_W+1)'(MAX_DIM)) begin
			h_lim = DIM_W'(MAX_DIM);
		end
	end

	// Bounds check and mirrored coordinates; the mirrors are only used in bounds.
	assign x_ext  = DIM_W'(pixel_x);
	assign y_ext  = DIM_W'(pixel_y);
	assign err    = (x_ext >= w_lim) || (y_ext >= h_lim);
	assign x_flip = w_lim - DIM_W'(1) - x_ext;
	assign y_flip = h_lim - DIM_W'(1) - y_ext;

	// Color conversion: widen RGB565, or swap red and blue of a wide source.
	always_comb begin
		if (cfg.source_is_wide) begin
			color = {source_pixel[7:0], source_pixel[15:8], source_pixel[23:16]};
		end else begin
			color = {source_pixel[15:11], 3'b000, source_pixel[10:5], 2'b00,
				source_pixel[4:0], 3'b000};
		end
		alpha = (cfg.rotation == ROT_NONE) ? ALPHA_CLEAR : ALPHA_OPAQUE;
	end

	// Pick the in-line offset and the line number for the rotation.
	always_comb begin
		map.error = err;
		map.pixel = {alpha, color};
		unique case (cfg.rotation)
			ROT_NONE: begin
				map.offset = x_ext;
				map.line   = y_ext;
			end
			ROT_90: begin
				map.offset = y_flip;
				map.line   = x_ext;
			end
			ROT_180: begin
				map.offset = x_flip;
				map.line   = y_flip;
			end
			ROT_270: begin
				map.offset = y_ext;
				map.line   = x_flip;
			end
		endcase
		if (err) begin
			map.offset = '0;
			map.line   = '0;
			map.pixel  = '0;
		end
	end

endmodule

// ===== design/pixel_format_rotate_writer_core.sv =====
// Top level of the pixel format rotate writer.
// Holds the configuration registers and the three-stage pixel pipeline.
// Depends on pfrw_pkg and pfrw_xlate.
//
// Usage:
//   Pixels enter on the in channel (pixel_x, pixel_y, source_pixel) and leave
//   on the out channel as a framebuffer word index, a 32-bit pixel and an
//   error flag. Both channels use a valid and ready handshake.
//   Configuration is written through the cfg channel (cfg_index, cfg_data),
//   which is always ready; writes must only happen while the block is idle.
//   Indexes beyond the register list are ignored.
//   A word passes three registers, the input, mapping and result registers,
//   before its result word is shown on the out channel. Throughput is one
//   word per cycle while the receiver takes results: the input, mapping and
//   result registers each advance whenever the stage after them is empty or
//   moving, so a new word is taken while a result waits.
//   The multiply by the line width and the final add sit between the mapping
//   and result registers.
//   When the receiver stalls, the pipeline fills and in_ready drops once all
//   three stages hold words; nothing is lost.
//   Reset empties the pipeline and loads the default configuration.
module pixel_format_rotate_writer_core import pfrw_pkg::*; #(
	parameter int MAX_DIM = PFRW_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_W-1:0]    pixel_x,
	input  logic [COORD_W-1:0]    pixel_y,
	input  logic [PIX_W-1:0]      source_pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [INDEX_W-1:0]    dest_index,
	output logic [PIX_W-1:0]      dest_pixel,
	output logic                  coord_error,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [1:0]        rotation_q;
	logic              source_is_wide_q;
	logic [LINE_W-1:0] line_width_q;
	logic [DIM_W-1:0]  picture_width_q;
	logic [DIM_W-1:0]  picture_height_q;
	cfg_t              cfg;

	logic               vld_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [PIX_W-1:0]   src_s1;
	logic               vld_s2;
	map_t               map_s2;
	map_t               map_next;
	logic               vld_q;
	logic [INDEX_W-1:0] index_q;
	logic [PIX_W-1:0]   pixel_q;
	logic               error_q;

	logic en_out;
	logic en_s2;
	logic en_s1;
	logic [INDEX_W-1:0] product;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q       <= ROT_NONE;
			source_is_wide_q <= 1'b0;
			line_width_q     <= LINE_WIDTH_RST;
			picture_width_q  <= PICTURE_WIDTH_RST;
			picture_height_q <= PICTURE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROTATION:       rotation_q       <= cfg_data[1:0];
				REG_SOURCE_IS_WIDE: source_is_wide_q <= cfg_data[0];
				REG_LINE_WIDTH:     line_width_q     <= cfg_data[LINE_W-1:0];
				REG_PICTURE_WIDTH:  picture_width_q  <= cfg_data[DIM_W-1:0];
				REG_PICTURE_HEIGHT: picture_height_q <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.rotation       = rotation_q;
	assign cfg.source_is_wide = source_is_wide_q;
	assign cfg.picture_width  = picture_width_q;
	assign cfg.picture_height = picture_height_q;

	// Stage enables: a stage loads when it is empty or its word moves on.
	assign en_out   = !vld_q || out_ready;
	assign en_s2    = !vld_s2 || en_out;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_out) begin
				vld_q <= vld_s2;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			x_s1   <= pixel_x;
			y_s1   <= pixel_y;
			src_s1 <= source_pixel;
		end
	end

	pfrw_xlate #(
		.MAX_DIM(MAX_DIM)
	) u_xlate (
		.cfg         (cfg),
		.pixel_x     (x_s1),
		.pixel_y     (y_s1),
		.source_pixel(src_s1),
		.map         (map_next)
	);

	// Mapping register.
	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			map_s2 <= map_next;
		end
	end

	// Index = offset + line * line_width, wrapped to the index width.
	assign product = INDEX_W'(map_s2.line) * INDEX_W'(line_width_q);

	// Result register.
	always_ff @(posedge clk) begin
		if (en_out && vld_s2) begin
			index_q <= product + INDEX_W'(map_s2.offset);
			pixel_q <= map_s2.pixel;
			error_q <= map_s2.error;
		end
	end

	assign out_valid   = vld_q;
	assign dest_index  = index_q;
	assign dest_pixel  = pixel_q;
	assign coord_error = error_q;

endmodule

// ===== design/pfrw_checker.sv =====
// Port-level checks for the pixel format rotate writer, bound to its top level.
// Depends on pfrw_pkg and pixel_format_rotate_writer_core.
module pfrw_checker import pfrw_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [INDEX_W-1:0]    dest_index,
	input logic [PIX_W-1:0]      dest_pixel,
	input logic                  coord_error
);

	// An out-of-picture word carries a zero index and a zero pixel.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coord_error |-> dest_index == '0 && dest_pixel == '0)
		else $error("error word with nonzero payload");

	// A good word has an alpha byte of either clear or opaque.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !coord_error |->
			dest_pixel[31:24] == ALPHA_CLEAR || dest_pixel[31:24] == ALPHA_OPAQUE)
		else $error("bad alpha byte");

	// The pipeline always takes a word when the receiver is taking one.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(dest_index) && $stable(dest_pixel) && $stable(coord_error))
		else $error("stalled result changed");

endmodule

bind pixel_format_rotate_writer_core pfrw_checker u_pfrw_checker (.*);
